>>> design/ssc_pkg.sv
package ssc_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACCURATE_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTISIG_DEFAULT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_OPCODE_VALUE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ELEMENT_BYTES = 2'd3;

  // register reset values
  localparam logic       RST_ACCURATE_MODE     = 1'b0;
  localparam logic [7:0] RST_MULTISIG_DEFAULT  = 8'd20;
  localparam logic [7:0] RST_MAX_OPCODE_VALUE  = 8'd185;
  localparam logic [15:0] RST_MAX_ELEMENT_BYTES = 16'd520;

  // opcode values
  localparam logic [7:0] OP_PUSH_MIN        = 8'h01;
  localparam logic [7:0] OP_PUSH_MAX        = 8'h4B;
  localparam logic [7:0] OP_PUSH_LEN1       = 8'h4C;
  localparam logic [7:0] OP_PUSH_LEN2       = 8'h4D;
  localparam logic [7:0] OP_PUSH_LEN4       = 8'h4E;
  localparam logic [7:0] OP_1               = 8'h51;
  localparam logic [7:0] OP_16              = 8'h60;
  localparam logic [7:0] OP_SMALL_BASE      = 8'h50;
  localparam logic [7:0] OP_SIG_CHECK       = 8'hAC;
  localparam logic [7:0] OP_SIG_CHECK_VFY   = 8'hAD;
  localparam logic [7:0] OP_MULTI_CHECK     = 8'hAE;
  localparam logic [7:0] OP_MULTI_CHECK_VFY = 8'hAF;
  localparam logic [7:0] OP_INVALID         = 8'hFF;

  // length byte counts for the pushdata forms
  localparam logic [2:0] LEN_BYTES_1 = 3'd1;
  localparam logic [2:0] LEN_BYTES_2 = 3'd2;
  localparam logic [2:0] LEN_BYTES_4 = 3'd4;

  typedef enum logic [2:0] {
    PH_OPCODE = 3'b001,
    PH_LENGTH = 3'b010,
    PH_DATA   = 3'b100
  } phase_t;

  typedef struct packed {
    logic        accurate_mode;
    logic [7:0]  multisig_default;
    logic [7:0]  max_opcode_value;
    logic [15:0] max_element_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0] script_byte;
    logic       is_final;
  } item_t;

  typedef struct packed {
    logic [15:0] sigop_count;
    logic        parse_ok;
    logic        push_only;
    logic        ops_valid;
  } result_t;

endpackage

>>> design/ssc_item_if.sv
interface ssc_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] script_byte;
  logic       is_final;

  modport source (output valid, output script_byte, output is_final, input ready);
  modport sink   (input valid, input script_byte, input is_final, output ready);
endinterface

>>> design/ssc_result_if.sv
interface ssc_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] sigop_count;
  logic        parse_ok;
  logic        push_only;
  logic        ops_valid;

  modport source (output valid, output sigop_count, output parse_ok, output push_only,
                  output ops_valid, input ready);
  modport sink   (input valid, input sigop_count, input parse_ok, input push_only,
                  input ops_valid, output ready);
endinterface

>>> design/ssc_cfg_regs.sv
module ssc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              we,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]     index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]    wdata,
  output ssc_pkg::cfg_t                     cfg
);

  ssc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accurate_mode     <= ssc_pkg::RST_ACCURATE_MODE;
      cfg_r.multisig_default  <= ssc_pkg::RST_MULTISIG_DEFAULT;
      cfg_r.max_opcode_value  <= ssc_pkg::RST_MAX_OPCODE_VALUE;
      cfg_r.max_element_bytes <= ssc_pkg::RST_MAX_ELEMENT_BYTES;
    end else if (we) begin
      case (index)
        ssc_pkg::CFG_ACCURATE_MODE:     cfg_r.accurate_mode     <= wdata[0];
        ssc_pkg::CFG_MULTISIG_DEFAULT:  cfg_r.multisig_default  <= wdata[7:0];
        ssc_pkg::CFG_MAX_OPCODE_VALUE:  cfg_r.max_opcode_value  <= wdata[7:0];
        ssc_pkg::CFG_MAX_ELEMENT_BYTES: cfg_r.max_element_bytes <= wdata[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/ssc_in_stage.sv
module ssc_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ssc_pkg::item_t  in_item,
  input  logic            advance,
  output logic            valid,
  output ssc_pkg::item_t  item
);

  logic           valid_r;
  ssc_pkg::item_t item_r;

  // free when empty or when the held item moves on this cycle
  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

>>> design/ssc_parser.sv
module ssc_parser #(
  parameter int unsigned COUNT_WIDTH = ssc_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  ssc_pkg::item_t    item,
  input  ssc_pkg::cfg_t     cfg,
  output logic              res_valid,
  output ssc_pkg::result_t  res
);

  ssc_pkg::phase_t        phase_r, phase_nxt;
  logic [2:0]             left_r, left_nxt;
  logic [31:0]            plen_r, plen_nxt;
  logic [1:0]             idx_r, idx_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [7:0]             prev_r, prev_nxt;
  logic                   ponly_r, ponly_nxt;
  logic                   valid_r, valid_nxt;

  logic                   add_en;
  logic [7:0]             add_n;
  logic [COUNT_WIDTH:0]   sum;
  logic [7:0]             b;
  logic                   ok;
  logic                   hi_nz;

  assign b = item.script_byte;

  // sig op charge for the current byte when taken as an opcode
  always_comb begin
    add_en = 1'b0;
    add_n  = 8'd0;
    if (b == ssc_pkg::OP_SIG_CHECK || b == ssc_pkg::OP_SIG_CHECK_VFY) begin
      add_en = 1'b1;
      add_n  = 8'd1;
    end else if (b == ssc_pkg::OP_MULTI_CHECK || b == ssc_pkg::OP_MULTI_CHECK_VFY) begin
      add_en = 1'b1;
      if (cfg.accurate_mode && prev_r >= ssc_pkg::OP_1 && prev_r <= ssc_pkg::OP_16) begin
        add_n = prev_r - ssc_pkg::OP_SMALL_BASE;
      end else begin
        add_n = cfg.multisig_default;
      end
    end
  end

  assign sum = {1'b0, count_r} + (COUNT_WIDTH+1)'(add_n);

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    plen_nxt  = plen_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    prev_nxt  = prev_r;
    ponly_nxt = ponly_r;
    valid_nxt = valid_r;

    case (phase_r)
      ssc_pkg::PH_LENGTH: begin
        plen_nxt = plen_r | (32'(b) << {idx_r, 3'b000});
        idx_nxt  = idx_r + 2'd1;
        left_nxt = (left_r != 3'd0) ? left_r - 3'd1 : left_r;
        if (left_nxt == 3'd0) begin
          if (plen_nxt > 32'(cfg.max_element_bytes)) valid_nxt = 1'b0;
          phase_nxt = (plen_nxt == 32'd0) ? ssc_pkg::PH_OPCODE : ssc_pkg::PH_DATA;
        end
      end
      ssc_pkg::PH_DATA: begin
        plen_nxt = (plen_r != 32'd0) ? plen_r - 32'd1 : plen_r;
        if (plen_nxt == 32'd0) phase_nxt = ssc_pkg::PH_OPCODE;
      end
      default: begin
        // opcode, also the fallback for an unused phase code
        if (b > cfg.max_opcode_value) valid_nxt = 1'b0;
        if (b > ssc_pkg::OP_16) ponly_nxt = 1'b0;
        if (add_en) begin
          count_nxt = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
        end
        prev_nxt = b;
        if (b >= ssc_pkg::OP_PUSH_MIN && b <= ssc_pkg::OP_PUSH_MAX) begin
          plen_nxt = 32'(b);
          if (plen_nxt > 32'(cfg.max_element_bytes)) valid_nxt = 1'b0;
          phase_nxt = ssc_pkg::PH_DATA;
        end else if (b == ssc_pkg::OP_PUSH_LEN1) begin
          left_nxt  = ssc_pkg::LEN_BYTES_1;
          idx_nxt   = 2'd0;
          plen_nxt  = 32'd0;
          phase_nxt = ssc_pkg::PH_LENGTH;
        end else if (b == ssc_pkg::OP_PUSH_LEN2) begin
          left_nxt  = ssc_pkg::LEN_BYTES_2;
          idx_nxt   = 2'd0;
          plen_nxt  = 32'd0;
          phase_nxt = ssc_pkg::PH_LENGTH;
        end else if (b == ssc_pkg::OP_PUSH_LEN4) begin
          left_nxt  = ssc_pkg::LEN_BYTES_4;
          idx_nxt   = 2'd0;
          plen_nxt  = 32'd0;
          phase_nxt = ssc_pkg::PH_LENGTH;
        end else begin
          phase_nxt = ssc_pkg::PH_OPCODE;
        end
      end
    endcase
  end

  // result from the state after this byte
  assign ok    = (phase_nxt == ssc_pkg::PH_OPCODE);
  assign hi_nz = ((count_nxt >> 16) != '0);

  assign res_valid       = fire && item.is_final;
  assign res.sigop_count = hi_nz ? 16'hFFFF : 16'(count_nxt);
  assign res.parse_ok    = ok;
  assign res.push_only   = ok && ponly_nxt;
  assign res.ops_valid   = ok && valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && item.is_final)) begin
      phase_r <= ssc_pkg::PH_OPCODE;
      left_r  <= 3'd0;
      plen_r  <= 32'd0;
      idx_r   <= 2'd0;
      count_r <= '0;
      prev_r  <= ssc_pkg::OP_INVALID;
      ponly_r <= 1'b1;
      valid_r <= 1'b1;
    end else if (fire) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      plen_r  <= plen_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
      prev_r  <= prev_nxt;
      ponly_r <= ponly_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

>>> design/ssc_out_reg.sv
module ssc_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  ssc_pkg::result_t  res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output ssc_pkg::result_t  out_res
);

  logic             valid_r;
  ssc_pkg::result_t res_r;

  assign free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

>>> design/script_sigop_scanner.sv
// script signature-op scanner: script bytes stream in one item per cycle, the
// last byte of each script flagged with is_final, and one result item comes
// out for each script. the result register loads at the edge where the final
// byte leaves the input register; with a free result register the final byte
// passes through the input register and then the result register. the scanner
// sustains one item per clock; the only stall is a final byte waiting for the
// result register when an earlier result has not yet been taken. the
// configuration registers should be written only while no script is in flight.
module script_sigop_scanner #(
  parameter int unsigned COUNT_WIDTH = ssc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ssc_item_if.sink                        in_item,
  ssc_result_if.source                    out_result,
  input  logic                            cfg_we,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  ssc_pkg::cfg_t    cfg;
  ssc_pkg::item_t   in_pay;
  ssc_pkg::item_t   s1_item;
  logic             s1_valid;
  logic             advance;
  logic             res_valid;
  ssc_pkg::result_t res;
  logic             out_free;
  ssc_pkg::result_t out_res;

  // configuration registers
  ssc_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  assign in_pay.script_byte = in_item.script_byte;
  assign in_pay.is_final    = in_item.is_final;

  // input register
  ssc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .in_item  (in_pay),
    .advance  (advance),
    .valid    (s1_valid),
    .item     (s1_item)
  );

  // a non-final byte always moves on; a final one needs room for its result
  assign advance = s1_valid && (!s1_item.is_final || out_free);

  // parse state and sig op count, updated once per item
  ssc_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .item      (s1_item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  ssc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .free      (out_free),
    .out_valid (out_result.valid),
    .out_ready (out_result.ready),
    .out_res   (out_res)
  );

  assign out_result.sigop_count = out_res.sigop_count;
  assign out_result.parse_ok    = out_res.parse_ok;
  assign out_result.push_only   = out_res.push_only;
  assign out_result.ops_valid   = out_res.ops_valid;

endmodule

>>> tb/ssc_tb_pkg.sv
`timescale 1ns / 1ps

package ssc_tb_pkg;
  import ssc_pkg::*;

  // tracks one script at a time and holds the tallies still owed by the scanner
  class script_checker;
    cfg_t       regs;
    phase_t     phase;
    logic [2:0] len_left;
    logic [31:0] push_len;
    logic [1:0] len_idx;
    logic [15:0] tally;
    logic [7:0] prev_op;
    logic       only_pushes;
    logic       within_limits;
    result_t    expected_tallies[$];
    int         mismatches;

    function new();
      regs.accurate_mode     = RST_ACCURATE_MODE;
      regs.multisig_default  = RST_MULTISIG_DEFAULT;
      regs.max_opcode_value  = RST_MAX_OPCODE_VALUE;
      regs.max_element_bytes = RST_MAX_ELEMENT_BYTES;
      mismatches = 0;
      clear_script();
    endfunction

    function void clear_script();
      phase         = PH_OPCODE;
      len_left      = '0;
      push_len      = '0;
      len_idx       = '0;
      tally         = '0;
      prev_op       = OP_INVALID;
      only_pushes   = 1'b1;
      within_limits = 1'b1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ACCURATE_MODE:     regs.accurate_mode     = data[0];
        CFG_MULTISIG_DEFAULT:  regs.multisig_default  = data[7:0];
        CFG_MAX_OPCODE_VALUE:  regs.max_opcode_value  = data[7:0];
        CFG_MAX_ELEMENT_BYTES: regs.max_element_bytes = data[15:0];
        default: ;
      endcase
    endfunction

    // saturating add
    function void add_sigops(int unsigned n);
      int unsigned s;
      s = int'(tally) + n;
      tally = (s > 32'd65535) ? 16'hFFFF : s[15:0];
    endfunction

    function void open_push();
      if (push_len > 32'(regs.max_element_bytes)) within_limits = 1'b0;
      phase = (push_len == 0) ? PH_OPCODE : PH_DATA;
    endfunction

    function void take_opcode(logic [7:0] b);
      if (b > regs.max_opcode_value) within_limits = 1'b0;
      if (b > OP_16) only_pushes = 1'b0;
      if (b == OP_SIG_CHECK || b == OP_SIG_CHECK_VFY) begin
        add_sigops(1);
      end else if (b == OP_MULTI_CHECK || b == OP_MULTI_CHECK_VFY) begin
        if (regs.accurate_mode && prev_op >= OP_1 && prev_op <= OP_16)
          add_sigops(int'(prev_op - OP_SMALL_BASE));
        else
          add_sigops(int'(regs.multisig_default));
      end
      prev_op = b;
      if (b >= OP_PUSH_MIN && b <= OP_PUSH_MAX) begin
        push_len = 32'(b);
        open_push();
      end else if (b >= OP_PUSH_LEN1 && b <= OP_PUSH_LEN4) begin
        len_left = (b == OP_PUSH_LEN1) ? LEN_BYTES_1 :
                   (b == OP_PUSH_LEN2) ? LEN_BYTES_2 : LEN_BYTES_4;
        len_idx  = '0;
        push_len = '0;
        phase    = PH_LENGTH;
      end else begin
        phase = PH_OPCODE;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      result_t r;
      logic    ok;
      case (phase)
        PH_LENGTH: begin
          push_len = push_len | (32'(b) << (8 * len_idx));
          len_idx  = len_idx + 2'd1;
          if (len_left != 0) len_left = len_left - 3'd1;
          if (len_left == 0) open_push();
        end
        PH_DATA: begin
          if (push_len != 0) push_len = push_len - 32'd1;
          if (push_len == 0) phase = PH_OPCODE;
        end
        default: take_opcode(b);
      endcase
      if (fin) begin
        ok            = (phase == PH_OPCODE);
        r.sigop_count = tally;
        r.parse_ok    = ok;
        r.push_only   = ok && only_pushes;
        r.ops_valid   = ok && within_limits;
        expected_tallies.push_back(r);
        clear_script();
      end
    endfunction

    function void check_tally(result_t got);
      result_t want;
      if (expected_tallies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: count=%0d ok=%b push=%b valid=%b",
                   got.sigop_count, got.parse_ok, got.push_only, got.ops_valid);
        return;
      end
      want = expected_tallies.pop_front();
      if (got.sigop_count !== want.sigop_count || got.parse_ok !== want.parse_ok ||
          got.push_only !== want.push_only || got.ops_valid !== want.ops_valid) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: want count=%0d ok=%b push=%b valid=%b,",
                    " got count=%0d ok=%b push=%b valid=%b"},
                   want.sigop_count, want.parse_ok, want.push_only, want.ops_valid,
                   got.sigop_count, got.parse_ok, got.push_only, got.ops_valid);
      end
    endfunction
  endclass

endpackage

>>> tb/script_sigop_scanner_tb.sv
`timescale 1ns / 1ps

module script_sigop_scanner_tb;
  import ssc_pkg::*;
  import ssc_tb_pkg::*;

  // opcodes the package has no name for
  localparam logic [7:0] OP_0           = 8'h00;
  localparam logic [7:0] OP_ABOVE_16    = OP_16 + 8'd1;
  localparam logic [7:0] OP_ABOVE_LIMIT = RST_MAX_OPCODE_VALUE + 8'd1;

  // generous ceiling, well above the slowest legal run
  localparam int CYCLE_LIMIT = 1000000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ssc_item_if   in_if ();
  ssc_result_if out_if ();

  script_sigop_scanner u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_if),
    .out_result (out_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  script_checker sb = new();

  logic [7:0] script_q[$];   // bytes of the script being built
  bit         steady;        // no idling on either side while set
  int         bytes_sent;
  int         cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // sample both channels at the rising edge; results first, then the new byte
  always @(posedge clk) begin : monitor
    result_t got;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got.sigop_count = out_if.sigop_count;
        got.parse_ok    = out_if.parse_ok;
        got.push_only   = out_if.push_only;
        got.ops_valid   = out_if.ops_valid;
        sb.check_tally(got);
      end
      if (in_if.valid && in_if.ready)
        sb.note_byte(in_if.script_byte, in_if.is_final);
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // result side back-pressure, changed on the falling edge
  initial begin : result_stalls
    int hold;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.script_byte <= b;
    in_if.is_final    <= fin;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
  endtask

  task automatic play_script();
    foreach (script_q[i]) send_item(script_q[i], i == script_q.size() - 1);
    bytes_sent += script_q.size();
    script_q.delete();
  endtask

  // let every owed tally come back, then give the result register time to settle
  task automatic drain();
    @(negedge clk);
    in_if.valid    <= 1'b0;
    in_if.is_final <= 1'b0;
    while (sb.expected_tallies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic setup(input logic [15:0] acc, input logic [15:0] dflt,
                       input logic [15:0] max_op, input logic [15:0] max_elem);
    write_reg(CFG_ACCURATE_MODE, acc);
    write_reg(CFG_MULTISIG_DEFAULT, dflt);
    write_reg(CFG_MAX_OPCODE_VALUE, max_op);
    write_reg(CFG_MAX_ELEMENT_BYTES, max_elem);
  endtask

  // push sizes: mostly tiny, some right around the element limit, a few large
  function automatic int pick_push_len();
    int r;
    int lim;
    r   = $urandom_range(0, 99);
    lim = int'(sb.regs.max_element_bytes);
    if (r < 55) return $urandom_range(0, 10);
    if (r < 75 && lim <= 300) return $urandom_range(lim > 0 ? lim - 1 : 0, lim + 1);
    if (r < 95) return $urandom_range(11, 80);
    return $urandom_range(200, 600);
  endfunction

  // complete push in one of the four encodings, with random payload
  function automatic void put_push(int n);
    int form;
    form = $urandom_range(0, 3);
    if (form == 0 && n <= 75) begin
      script_q.push_back(8'(n));
    end else if (form == 1 && n <= 255) begin
      script_q.push_back(OP_PUSH_LEN1);
      script_q.push_back(8'(n));
    end else if (form == 2) begin
      script_q.push_back(OP_PUSH_LEN2);
      script_q.push_back(8'(n));
      script_q.push_back(8'(n >> 8));
    end else begin
      script_q.push_back(OP_PUSH_LEN4);
      script_q.push_back(8'(n));
      script_q.push_back(8'(n >> 8));
      script_q.push_back(8'(n >> 16));
      script_q.push_back(8'(n >> 24));
    end
    repeat (n) script_q.push_back(8'($urandom));
  endfunction

  // a non-push operation, biased towards the ones that count signature ops
  function automatic void put_plain_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      script_q.push_back(8'($urandom_range(OP_1, OP_16)));
      script_q.push_back($urandom_range(0, 1) ? OP_MULTI_CHECK : OP_MULTI_CHECK_VFY);
    end else if (r < 45) begin
      script_q.push_back($urandom_range(0, 1) ? OP_MULTI_CHECK : OP_MULTI_CHECK_VFY);
    end else if (r < 65) begin
      script_q.push_back($urandom_range(0, 1) ? OP_SIG_CHECK : OP_SIG_CHECK_VFY);
    end else if (r < 80) begin
      script_q.push_back(8'($urandom_range(OP_SMALL_BASE - 8'd1, OP_16)));
    end else begin
      script_q.push_back(8'($urandom_range(OP_PUSH_LEN4 + 8'd1, 255)));
    end
  endfunction

  function automatic void put_wellformed(int ops);
    repeat (ops) begin
      if ($urandom_range(0, 1)) put_push(pick_push_len());
      else put_plain_op();
    end
  endfunction

  // a push cut short: in its opcode, its length bytes or its payload
  function automatic void put_cut_push();
    int n;
    case ($urandom_range(0, 2))
      0: begin
        script_q.push_back(OP_PUSH_LEN4);
        if ($urandom_range(0, 1)) begin
          repeat (4) script_q.push_back(8'($urandom));
          repeat ($urandom_range(0, 3)) script_q.push_back(8'($urandom));
        end else begin
          repeat ($urandom_range(0, 3)) script_q.push_back(8'($urandom));
        end
      end
      1: begin
        if ($urandom_range(0, 1)) begin
          script_q.push_back(OP_PUSH_LEN1);
        end else begin
          script_q.push_back(OP_PUSH_LEN2);
          repeat ($urandom_range(0, 1)) script_q.push_back(8'($urandom));
        end
      end
      default: begin
        n = $urandom_range(1, 75);
        script_q.push_back(8'(n));
        repeat ($urandom_range(0, n - 1)) script_q.push_back(8'($urandom));
      end
    endcase
  endfunction

  function automatic void build_random_script();
    int k;
    k = $urandom_range(0, 99);
    if (k < 3) begin
      // long multisig run that can push the count into saturation
      repeat ($urandom_range(257, 300))
        script_q.push_back($urandom_range(0, 1) ? OP_MULTI_CHECK : OP_MULTI_CHECK_VFY);
    end else if (k < 65) begin
      put_wellformed($urandom_range(1, 8));
    end else if (k < 85) begin
      put_wellformed($urandom_range(0, 4));
      put_cut_push();
    end else begin
      // raw noise, any byte at all
      repeat ($urandom_range(1, 8)) script_q.push_back(8'($urandom));
    end
  endfunction

  function automatic logic [15:0] pick_setting(int unsigned width_top);
    int r;
    r = $urandom_range(0, 4);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'(width_top);
    return 16'($urandom_range(0, width_top));
  endfunction

  initial begin : stimulus
    int phase_bytes;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.script_byte = '0;
    in_if.is_final    = 1'b0;
    steady            = 1'b0;
    bytes_sent        = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: one-byte scripts, each push form, truncations, limits
    script_q = '{OP_0};                                        play_script();
    script_q = '{OP_SIG_CHECK};                                play_script();
    script_q = '{OP_1 + 8'd1, OP_MULTI_CHECK};                 play_script();
    script_q = '{OP_PUSH_MIN, 8'hFF};                          play_script();
    script_q = '{OP_PUSH_LEN1, 8'h00};                         play_script();
    script_q = '{OP_PUSH_LEN4, 8'h01, 8'h00, 8'h00, 8'h00, 8'h7F}; play_script();
    script_q = '{OP_PUSH_LEN4, 8'hFF};                         play_script();
    script_q = '{OP_PUSH_MAX, 8'h01, 8'h02};                   play_script();
    script_q = '{OP_PUSH_LEN2, 8'h09, 8'h02};                  play_script();
    script_q = '{OP_ABOVE_LIMIT};                              play_script();
    script_q = '{RST_MAX_OPCODE_VALUE};                        play_script();
    script_q = '{OP_ABOVE_16};                                 play_script();
    script_q = '{OP_16};                                       play_script();
    script_q = '{OP_INVALID};                                  play_script();
    script_q = '{OP_SIG_CHECK_VFY, OP_MULTI_CHECK_VFY};        play_script();
    drain();

    // accurate counting: small-number prefix, wrong prefix, none, and across scripts
    write_reg(CFG_ACCURATE_MODE, 16'd1);
    script_q = '{OP_16, OP_MULTI_CHECK_VFY};                   play_script();
    script_q = '{OP_1, OP_MULTI_CHECK};                        play_script();
    script_q = '{OP_SMALL_BASE, OP_MULTI_CHECK};               play_script();
    script_q = '{OP_MULTI_CHECK};                              play_script();
    script_q = '{OP_1 + 8'd2};                                 play_script();
    script_q = '{OP_MULTI_CHECK};                              play_script();
    drain();

    // limits and the multisig default at their minimum, accurate mode on
    setup(16'd1, 16'd0, 16'd0, 16'd0);
    script_q = '{OP_0};                                        play_script();
    script_q = '{OP_PUSH_MIN, 8'h00};                          play_script();
    script_q = '{OP_PUSH_LEN1, 8'h00};                         play_script();
    script_q = '{OP_MULTI_CHECK};                              play_script();
    drain();

    // limits and the multisig default at their maximum, accurate mode off; a long multisig run saturates the count
    setup(16'd0, 16'd255, 16'd255, 16'hFFFF);
    script_q = '{OP_INVALID};                                  play_script();
    repeat (260) script_q.push_back(OP_MULTI_CHECK);
    play_script();
    drain();

    // random phases, each with fresh settings; junk above the field widths is dropped
    bytes_sent = 0;
    for (int p = 0; p < 5; p++) begin
      steady = 1'b0;
      setup({15'($urandom), 1'($urandom)},
            {8'($urandom), 8'(pick_setting(255))},
            {8'($urandom), 8'(pick_setting(255))},
            pick_setting(65535));
      phase_bytes = bytes_sent;
      while (bytes_sent - phase_bytes < 40) begin
        // occasional stretches with no idling at all
        steady = ($urandom_range(0, 4) == 0);
        build_random_script();
        play_script();
      end
      drain();
    end

    // wait out the last results, then a little longer for strays
    steady = 1'b0;
    while (sb.expected_tallies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
